FILE: src/icts_pkg.sv
// Shared constants, codes and types for the inverse CDF table sampler.
`timescale 1ns / 1ps
package icts_pkg;
   localparam int TABLE_ENTRIES = 4096;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int SUM_W = 36;
   localparam int GRID_W = 32;
   localparam int DENS_W = 24;
   localparam int UNI_W = 24;
   localparam int TGT_W = SUM_W + UNI_W;
   localparam int FRAC_W = TGT_W + 2;
   localparam int FH_W = FRAC_W - UNI_W;
   localparam int FH_LO_W = 18;
   localparam int MUL_A_W = 26;
   localparam int DG_W = GRID_W + 1;
   localparam int PROD_W = MUL_A_W + DG_W;
   localparam int ACC_W = 64;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_APPEND = 2'd1;
   localparam cmd_type CMD_DRAW   = 2'd2;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ZERO_SUM = 2'd1;
   localparam status_type ST_TOO_FEW  = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [SUM_W-1:0]  cum;
      logic [GRID_W-1:0] grid;
   } store_wr_type;
endpackage

FILE: src/icts_if.sv
// Request and response channel interfaces of the sampler.
`timescale 1ns / 1ps
interface icts_req_if;
   import icts_pkg::*;
   logic               valid;
   logic               ready;
   cmd_type            cmd;
   logic [GRID_W-1:0]  grid_value;
   logic [DENS_W-1:0]  density;
   logic [UNI_W-1:0]   uniform;
   modport source (output valid, cmd, grid_value, density, uniform, input ready);
   modport sink (input valid, cmd, grid_value, density, uniform, output ready);
endinterface

interface icts_rsp_if;
   import icts_pkg::*;
   logic              valid;
   logic              ready;
   logic [GRID_W-1:0] sample_value;
   status_type        status;
   modport source (output valid, sample_value, status, input ready);
   modport sink (input valid, sample_value, status, output ready);
endinterface

FILE: src/icts_store.sv
// Table memories: running sums and grid points, one write and one read port.
`timescale 1ns / 1ps
module icts_store (
   input  logic                       clock,
   input  icts_pkg::store_wr_type     wr,
   input  logic [icts_pkg::IDX_W-1:0] rd_addr,
   output logic [icts_pkg::SUM_W-1:0] rd_cum,
   output logic [icts_pkg::GRID_W-1:0] rd_grid
);
   import icts_pkg::*;

   logic [SUM_W-1:0]  cum_mem [TABLE_ENTRIES];
   logic [GRID_W-1:0] grid_mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cum_mem[wr.addr]  <= wr.cum;
         grid_mem[wr.addr] <= wr.grid;
      end
      rd_cum  <= cum_mem[rd_addr];
      rd_grid <= grid_mem[rd_addr];
   end
endmodule

FILE: src/icts_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module icts_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [icts_pkg::TGT_W-1:0] dividend,
   input  logic [icts_pkg::SUM_W-1:0] divisor,
   output logic                       done,
   output logic [icts_pkg::TGT_W-1:0] quotient,
   output logic                       rem_nz
);
   import icts_pkg::*;
   localparam int CW = $clog2(TGT_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  div_ff, div_in;
   logic [TGT_W-1:0]  quo_ff, quo_in;
   logic [SUM_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, quo_ff[TGT_W-1]};
   assign ge = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(TGT_W);
         rem_in = '0;
         div_in = divisor;
         quo_in = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? SUM_W'(trial - {1'b0, div_ff}) : trial[SUM_W-1:0];
         quo_in = {quo_ff[TGT_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign rem_nz = |rem_ff;
endmodule

FILE: src/inverse_cdf_table_sampler.sv
// Top level: table build, binary search, interpolation and result register.
//
//   channel   dir   signals                                   transfer when
//   req_if    in    cmd, grid_value, density, uniform         valid && ready
//   rsp_if    out   sample_value, status                      valid && ready
//
// Clear, append and unused commands go from idle straight to the finish state. A
// draw runs the binary search, reads two table entries, runs the serial divider
// when the segment width is nonzero, then multiplies and sums. The divider and
// the one-port table read in the search loop set the length of a draw.
// A new request is taken only after the previous one reaches the result
// register; that register holds a stalled result while the next one works.
// Synchronous reset empties the table; the memories themselves are not cleared.
`timescale 1ns / 1ps
module inverse_cdf_table_sampler (
   input  logic      clock,
   input  logic      reset,
   icts_req_if.sink  req_if,
   icts_rsp_if.source rsp_if
);
   import icts_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH_RD, S_SEARCH_CMP, S_RD_PREV, S_RD_CUR, S_CAPTURE,
      S_DIV, S_MUL_LO, S_MUL_HI, S_MUL_FL, S_SUM, S_RESULT, S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SUM_W-1:0]          total_ff, total_in;
   logic [TGT_W-1:0]          target_ff, target_in;
   logic [CNT_W-1:0]          lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]          mid_ff, mid_in, idx_ff, idx_in;
   logic [SUM_W-1:0]          cum_prev_ff, cum_prev_in;
   logic [GRID_W-1:0]         grid_prev_ff, grid_prev_in;
   logic                      neg_ff, neg_in;
   logic [TGT_W-1:0]          mag_ff, mag_in;
   logic [SUM_W-1:0]          width_ff, width_in;
   logic signed [DG_W-1:0]    dg_ff, dg_in;
   logic signed [FRAC_W-1:0]  frac_ff, frac_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [GRID_W-1:0]         sample_ff, sample_in;
   status_type                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [GRID_W-1:0]         rsp_sample_ff, rsp_sample_in;
   status_type                rsp_status_ff, rsp_status_in;

   store_wr_type              wr;
   logic [IDX_W-1:0]          rd_addr;
   logic [SUM_W-1:0]          rd_cum;
   logic [GRID_W-1:0]         rd_grid;
   logic                      div_start, div_done, div_rnz;
   logic [TGT_W-1:0]          div_quo;

   logic [CNT_W-1:0]          mid_full, lo_clamp, last_idx;
   logic [SUM_W:0]            sum_wide;
   logic [TGT_W:0]            num_diff;
   logic signed [FRAC_W-1:0]  fh;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [ACC_W-1:0]   prod64, res64;

   icts_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_cum  (rd_cum),
      .rd_grid (rd_grid)
   );

   icts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_in),
      .divisor  (width_in),
      .done     (div_done),
      .quotient (div_quo),
      .rem_nz   (div_rnz)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.sample_value = rsp_sample_ff;
   assign rsp_if.status = rsp_status_ff;

   assign mid_full = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last_idx = count_ff - CNT_W'(1);
   assign lo_clamp = (lo_ff == '0) ? CNT_W'(1) : lo_ff;
   assign sum_wide = {1'b0, total_ff} + (SUM_W + 1)'(req_if.density);
   assign num_diff = {1'b0, target_ff} - {1'b0, cum_prev_ff, {UNI_W{1'b0}}};
   assign fh = frac_ff >>> UNI_W;
   assign prod64 = ACC_W'(prod_ff);
   assign res64 = $signed({{(ACC_W - GRID_W){1'b0}}, grid_prev_ff}) + acc_ff;

   always_comb begin
      unique case (state_ff)
         S_MUL_LO: mul_a = $signed({{(MUL_A_W - FH_LO_W){1'b0}}, fh[FH_LO_W-1:0]});
         S_MUL_HI: mul_a = MUL_A_W'($signed(fh[FH_W-1:FH_LO_W]));
         default:  mul_a = $signed({{(MUL_A_W - UNI_W){1'b0}}, frac_ff[UNI_W-1:0]});
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_RD_PREV: rd_addr = idx_ff - IDX_W'(1);
         S_RD_CUR:  rd_addr = idx_ff;
         default:   rd_addr = mid_full[IDX_W-1:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      target_in = target_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      idx_in = idx_ff;
      cum_prev_in = cum_prev_ff;
      grid_prev_in = grid_prev_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      width_in = width_ff;
      dg_in = dg_ff;
      frac_in = frac_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      sample_in = sample_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_status_in = rsp_status_ff;
      wr = '0;
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               sample_in = '0;
               status_in = ST_OK;
               state_in = S_FINISH;
               unique case (req_if.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  CMD_APPEND: begin
                     if (count_ff >= CNT_W'(TABLE_ENTRIES)) begin
                        status_in = ST_FULL;
                     end else begin
                        total_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                        wr.en = 1'b1;
                        wr.addr = count_ff[IDX_W-1:0];
                        wr.cum = total_in;
                        wr.grid = req_if.grid_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DRAW: begin
                     if (count_ff < CNT_W'(2)) begin
                        status_in = ST_TOO_FEW;
                     end else if (total_ff == '0) begin
                        status_in = ST_ZERO_SUM;
                     end else begin
                        target_in = TGT_W'(req_if.uniform) * TGT_W'(total_ff);
                        lo_in = '0;
                        hi_in = count_ff;
                        state_in = S_SEARCH_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in = mid_full[IDX_W-1:0];
               state_in = S_SEARCH_CMP;
            end else begin
               idx_in = (lo_clamp > last_idx) ? last_idx[IDX_W-1:0]
                                              : lo_clamp[IDX_W-1:0];
               state_in = S_RD_PREV;
            end
         end
         S_SEARCH_CMP: begin
            if ({rd_cum, {UNI_W{1'b0}}} >= target_ff) begin
               hi_in = CNT_W'(mid_ff);
            end else begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end
            state_in = S_SEARCH_RD;
         end
         S_RD_PREV: state_in = S_RD_CUR;
         S_RD_CUR: begin
            cum_prev_in = rd_cum;
            grid_prev_in = rd_grid;
            state_in = S_CAPTURE;
         end
         S_CAPTURE: begin
            neg_in = num_diff[TGT_W];
            mag_in = num_diff[TGT_W] ? TGT_W'(-num_diff) : num_diff[TGT_W-1:0];
            width_in = rd_cum - cum_prev_ff;
            dg_in = $signed({1'b0, rd_grid}) - $signed({1'b0, grid_prev_ff});
            if (width_in == '0) begin
               frac_in = '0;
               state_in = S_MUL_LO;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               frac_in = neg_ff ? -($signed({2'b00, div_quo}) + FRAC_W'(div_rnz))
                                : $signed({2'b00, div_quo});
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            prod_in = mul_a * dg_ff;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            acc_in = prod64;
            prod_in = mul_a * dg_ff;
            state_in = S_MUL_FL;
         end
         S_MUL_FL: begin
            acc_in = acc_ff + (prod64 <<< FH_LO_W);
            prod_in = mul_a * dg_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            acc_in = acc_ff + (prod64 >>> UNI_W);
            state_in = S_RESULT;
         end
         S_RESULT: begin
            priority if (res64[ACC_W-1]) begin
               sample_in = '0;
            end else if (res64[ACC_W-2:GRID_W] != '0) begin
               sample_in = '1;
            end else begin
               sample_in = res64[GRID_W-1:0];
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sample_in = sample_ff;
               rsp_status_in = status_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      div_start = (state_ff == S_CAPTURE) && (width_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff <= target_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
      cum_prev_ff <= cum_prev_in;
      grid_prev_ff <= grid_prev_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      width_ff <= width_in;
      dg_ff <= dg_in;
      frac_ff <= frac_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      sample_ff <= sample_in;
      status_ff <= status_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_status_ff <= rsp_status_in;
   end
endmodule

FILE: src/icts_checker.sv
// Port-level assertions for the sampler and their bind to the top level.
`timescale 1ns / 1ps
module icts_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [icts_pkg::GRID_W-1:0]  rsp_sample_value,
   input icts_pkg::status_type         rsp_status
);
   import icts_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while one is in flight");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_sample_value == '0))
      else $error("nonzero sample with error status");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_sample_value) && $stable(rsp_status)))
      else $error("stalled result changed");
endmodule

bind inverse_cdf_table_sampler icts_checker u_icts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sample_value (rsp_if.sample_value),
   .rsp_status       (rsp_if.status)
);

FILE: test/inverse_cdf_table_sampler_test.sv
// Self-checking testbench for the inverse CDF table sampler: directed and random traffic and scoreboard.
`timescale 1ns / 1ps
module inverse_cdf_table_sampler_test;
   import icts_pkg::*;

   typedef struct {
      cmd_type           cmd;
      logic [GRID_W-1:0] grid;
      logic [DENS_W-1:0] dens;
      logic [UNI_W-1:0]  uni;
   } request_type;

   typedef struct {
      logic [GRID_W-1:0] sample;
      status_type        status;
   } sample_type;

   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam logic [SUM_W-1:0] SUM_SAT = '1;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   icts_req_if req_if ();
   icts_rsp_if rsp_if ();

   inverse_cdf_table_sampler i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   request_type pending_requests[$];
   sample_type  expected_samples[$];

   logic [SUM_W-1:0]  model_cum[TABLE_ENTRIES];
   logic [GRID_W-1:0] model_grid[TABLE_ENTRIES];
   int                model_count = 0;
   logic [SUM_W-1:0]  model_total = '0;

   int  errors = 0;
   int  quiet_cycles = 0;
   bit  calm = 0;
   bit  hold_request = 0;
   bit  hold_done = 0;
   int  hold_count = 0;
   bit  req_taken = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint floor_div(longint x, longint d);
      if (x >= 0) return x / d;
      return -(((-x) + d - 1) / d);
   endfunction

   function automatic logic [GRID_W-1:0] interpolate_sample(logic [UNI_W-1:0] uni);
      logic [TGT_W-1:0] target;
      int lo, hi, mid, idx;
      longint num, width, frac, dg;
      logic signed [127:0] f_wide, dg_wide, offset, res;
      target = TGT_W'(uni) * TGT_W'(model_total);
      lo = 0;
      hi = model_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if ({model_cum[mid], 24'd0} >= target) hi = mid;
         else lo = mid + 1;
      end
      idx = lo;
      if (idx < 1) idx = 1;
      if (idx > model_count - 1) idx = model_count - 1;
      num = longint'(target) - longint'({model_cum[idx-1], 24'd0});
      width = longint'(model_cum[idx]) - longint'(model_cum[idx-1]);
      frac = (width == 0) ? 0 : floor_div(num, width);
      dg = longint'(model_grid[idx]) - longint'(model_grid[idx-1]);
      f_wide = frac;
      dg_wide = dg;
      offset = (f_wide * dg_wide) >>> 24;
      res = $signed({96'd0, model_grid[idx-1]}) + offset;
      if (res < 0) return '0;
      if (res > 128'sh0FFFF_FFFF) return '1;
      return res[GRID_W-1:0];
   endfunction

   function automatic sample_type predict_sample(request_type r);
      sample_type s;
      logic [SUM_W:0] sum;
      s.sample = '0;
      s.status = ST_OK;
      case (r.cmd)
         CMD_CLEAR: begin
            model_count = 0;
            model_total = '0;
         end
         CMD_APPEND: begin
            if (model_count >= TABLE_ENTRIES) s.status = ST_FULL;
            else begin
               sum = {1'b0, model_total} + (SUM_W + 1)'(r.dens);
               model_total = sum[SUM_W] ? SUM_SAT : sum[SUM_W-1:0];
               model_cum[model_count] = model_total;
               model_grid[model_count] = r.grid;
               model_count++;
            end
         end
         CMD_DRAW: begin
            if (model_count < 2) s.status = ST_TOO_FEW;
            else if (model_total == 0) s.status = ST_ZERO_SUM;
            else s.sample = interpolate_sample(r.uni);
         end
         default: ;
      endcase
      return s;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
         req_if.cmd <= CMD_CLEAR;
         req_if.grid_value <= '0;
         req_if.density <= '0;
         req_if.uniform <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
            req_if.valid <= 1;
            req_if.cmd <= pending_requests[0].cmd;
            req_if.grid_value <= pending_requests[0].grid;
            req_if.density <= pending_requests[0].dens;
            req_if.uniform <= pending_requests[0].uni;
         end else begin
            req_if.valid <= 0;
         end
      end
   end

   // receiver ready, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1;
         hold_count <= 400;
         rsp_if.ready <= 0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= calm || $urandom_range(99) >= 31;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      sample_type got, want;
      req_taken = 0;
      if (!reset) begin
         quiet_cycles++;
         if (req_if.valid && req_if.ready) begin
            req_taken = 1;
            quiet_cycles = 0;
            want = predict_sample(pending_requests.pop_front());
            expected_samples = {expected_samples, want};
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            got.sample = rsp_if.sample_value;
            got.status = rsp_if.status;
            if (expected_samples.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer sample=%h status=%0d",
                        $realtime, got.sample, got.status);
            end else begin
               want = expected_samples.pop_front();
               if (got.sample !== want.sample) begin
                  errors++;
                  $display("%0t: sample_value expected %h actual %h",
                           $realtime, want.sample, got.sample);
               end
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $realtime, want.status, got.status);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("inverse_cdf_table_sampler verification failed");
            $finish;
         end
      end
   end

   task automatic push(cmd_type c, logic [GRID_W-1:0] g, logic [DENS_W-1:0] d,
                       logic [UNI_W-1:0] u);
      request_type r;
      r.cmd = c;
      r.grid = g;
      r.dens = d;
      r.uni = u;
      pending_requests = {pending_requests, r};
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || expected_samples.size() > 0)
         @(posedge clock);
   endtask

   task automatic random_table(int n);
      logic [GRID_W-1:0] g;
      int k;
      g = $urandom_range(3) == 0 ? $urandom : $urandom_range(1000);
      push(CMD_CLEAR, $urandom, DENS_W'($urandom), UNI_W'($urandom));
      for (k = 0; k < n; k++) begin
         case ($urandom_range(5))
            0: g = $urandom;
            1: g = g - $urandom_range(5000);
            default: g = g + $urandom_range(100000);
         endcase
         push(CMD_APPEND, g,
              $urandom_range(4) == 0 ? 24'd0 :
              ($urandom_range(3) == 0 ? DENS_W'($urandom) : DENS_W'($urandom_range(300))),
              UNI_W'($urandom));
      end
   endtask

   initial begin
      int n, k, items;
      repeat (2) @(posedge clock);
      reset <= 0;

      push(CMD_DRAW, '0, '0, 24'h800000);
      push(CMD_APPEND, 32'hFFFFFFFF, 24'hFFFFFF, '0);
      push(CMD_DRAW, '0, '0, 24'hFFFFFF);
      push(CMD_CLEAR, '0, '0, '0);
      push(CMD_APPEND, 32'd100, 24'd0, '0);
      push(CMD_APPEND, 32'd200, 24'd0, '0);
      push(CMD_DRAW, '1, '1, 24'h400000);
      push(CMD_APPEND, 32'd0, 24'd10, '0);
      push(CMD_APPEND, 32'hFFFFFFFF, 24'hFFFFFF, '0);
      push(CMD_APPEND, 32'hFFFFFFFF, 24'd0, '0);
      push(CMD_DRAW, '0, '0, 24'd0);
      push(CMD_DRAW, '0, '0, 24'hFFFFFF);
      push(CMD_DRAW, '0, '0, 24'h800000);
      push(CMD_UNUSED, '1, '1, '1);
      push(CMD_DRAW, '0, '0, 24'h000001);
      push(CMD_CLEAR, '1, '1, '1);
      push(CMD_APPEND, 32'd1000, 24'hFFFFFF, '0);
      push(CMD_APPEND, 32'd0, 24'd1, '0);
      push(CMD_DRAW, '0, '0, 24'd0);
      push(CMD_DRAW, '0, '0, 24'hFFFFFF);
      drain();

      hold_request = 1;
      items = 0;
      while (items < 930) begin
         calm = items >= 300 && items < 420;
         if (items >= 500 && items < 520) drain();
         n = $urandom_range(9) == 0 ? $urandom_range(1) : $urandom_range(2, 24);
         random_table(n);
         items += n + 1;
         for (k = $urandom_range(2, 8); k > 0; k--) begin
            case ($urandom_range(19))
               0: push(CMD_UNUSED, $urandom, DENS_W'($urandom), UNI_W'($urandom));
               1: push(CMD_APPEND, $urandom, DENS_W'($urandom), UNI_W'($urandom));
               default: push(CMD_DRAW, $urandom, DENS_W'($urandom), UNI_W'($urandom));
            endcase
            items++;
         end
         while (pending_requests.size() > 40) @(posedge clock);
      end
      calm = 0;

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0) $display("inverse_cdf_table_sampler verification clean");
      else $display("inverse_cdf_table_sampler verification failed");
      $finish;
   end
endmodule
